// ===== hw/rtl/crt_pkg.sv =====
// Shared types, constants and register codes of the cyclic relay timer.
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

    // Button masks, tested in this order
    localparam logic [7:0] BTN_FAN_MASK    = 8'h09;
    localparam logic [7:0] BTN_BURNER_MASK = 8'h20;
    localparam logic [7:0] BTN_RESTART_MASK = 8'h84;
    localparam logic [7:0] BTN_OFF_MASK    = 8'h10;

    localparam logic [5:0] STEPS_PER_HOUR  = 6'd60;
    localparam logic [7:0] HOUR_SATURATE   = 8'd250;
    localparam logic [7:0] HOUR_MID_START  = 8'd2;
    localparam logic [7:0] HOUR_LATE_START = 8'd4;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_BUTTON = 1'b1;

    typedef enum logic [2:0] {
        REG_TICKS_PER_STEP   = 3'd0,
        REG_SHUTOFF_HOURS    = 3'd1,
        REG_FAN_ON_STEPS     = 3'd2,
        REG_FAN_OFF_STEPS    = 3'd3,
        REG_BURNER_ON_STEPS  = 3'd4,
        REG_BURNER_OFF_EARLY = 3'd5,
        REG_BURNER_OFF_MID   = 3'd6,
        REG_BURNER_OFF_LATE  = 3'd7
    } t_reg_index;

    typedef struct packed {
        logic [3:0] ticks_per_step;
        logic [7:0] shutoff_hours;
        logic [7:0] fan_on_steps;
        logic [7:0] fan_off_steps;
        logic [7:0] burner_on_steps;
        logic [7:0] burner_off_early;
        logic [7:0] burner_off_mid;
        logic [7:0] burner_off_late;
    } t_cfg;

    typedef struct packed {
        logic [3:0] tick_count;
        logic [7:0] step_count;
        logic [5:0] steps_in_hour;
        logic [7:0] hour_count;
        logic       fan_selected;
        logic       relay_level;
    } t_state;

    typedef struct packed {
        logic       mode;
        logic [7:0] button_code;
    } t_item;

    typedef struct packed {
        logic running;
        logic fan_mode;
        logic relay_on;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        ticks_per_step:   4'd8,
        shutoff_hours:    8'd8,
        fan_on_steps:     8'd1,
        fan_off_steps:    8'd3,
        burner_on_steps:  8'd10,
        burner_off_early: 8'd10,
        burner_off_mid:   8'd20,
        burner_off_late:  8'd30
    };

    localparam t_state STATE_RESET = '{
        tick_count:    4'd0,
        step_count:    8'd0,
        steps_in_hour: 6'd0,
        hour_count:    8'd0,
        fan_selected:  1'b0,
        relay_level:   1'b1
    };

endpackage

`default_nettype wire

// ===== hw/rtl/cyclic_relay_timer_with_shutoff.sv =====
// Top level of the cyclic relay timer with run-time shutoff.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+----------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tuser: mode, tdata: button_code
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: relay_on, fan_mode, running
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Every beat passes from acceptance into the input register, then through
// the step logic into the result register. Throughput is one beat per cycle
// while m_axis_tready is high; the state registers close the only loop.
// A stalled result holds the result register; the input register still takes
// one more beat, after which s_axis_tready drops until the result drains.
// Synchronous active-low reset restores the register defaults and the
// burner schedule with the relay energised. Config writes are always taken.
`timescale 1ns / 1ps
`default_nettype none

module cyclic_relay_timer_with_shutoff
    import crt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input beats
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] button_code
    input  wire logic       s_axis_tuser,   // [0] mode: 0 tick, 1 button
    // result beats
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [0] relay_on, [1] fan_mode, [2] running, zeros above
    // configuration writes
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result r_result;
    t_item   r_item;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    crt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance the held beat when the result slot is empty or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.mode        <= s_axis_tuser;
            r_item.button_code <= s_axis_tdata;
        end
    end

    crt_step u_step (
        .i_state  (r_state),
        .i_cfg    (cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Timer state: commit only when a beat advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_result.running, r_result.fan_mode, r_result.relay_on};

    // A beat that advances always leaves a result behind
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced beat produced no result");

    // The hour rollover keeps the step counter within one hour
    a_sih_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.steps_in_hour < STEPS_PER_HOUR)
        else $error("steps_in_hour out of range");

    // A forced-off button leaves the relay de-energised
    a_forced_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_item.mode == MODE_BUTTON && (|(r_item.button_code & BTN_OFF_MASK)))
        |=> !r_result.relay_on)
        else $error("forced off left relay on");

    // Input holding register never waits while the result slot is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |-> advance)
        else $error("held beat stalled with free result slot");

endmodule

`default_nettype wire

// ===== hw/rtl/crt_cfg.sv =====
// Configuration register file of the cyclic relay timer.
`timescale 1ns / 1ps
`default_nettype none

module crt_cfg
    import crt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr_en,
    input  wire logic [2:0] i_wr_index,
    input  wire logic [7:0] i_wr_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_wr_en) begin
            unique case (t_reg_index'(i_wr_index))
                REG_TICKS_PER_STEP:   r_cfg.ticks_per_step   <= i_wr_data[3:0];
                REG_SHUTOFF_HOURS:    r_cfg.shutoff_hours    <= i_wr_data;
                REG_FAN_ON_STEPS:     r_cfg.fan_on_steps     <= i_wr_data;
                REG_FAN_OFF_STEPS:    r_cfg.fan_off_steps    <= i_wr_data;
                REG_BURNER_ON_STEPS:  r_cfg.burner_on_steps  <= i_wr_data;
                REG_BURNER_OFF_EARLY: r_cfg.burner_off_early <= i_wr_data;
                REG_BURNER_OFF_MID:   r_cfg.burner_off_mid   <= i_wr_data;
                REG_BURNER_OFF_LATE:  r_cfg.burner_off_late  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/crt_step.sv =====
// Next-state and result logic for one tick or button beat.
`timescale 1ns / 1ps
`default_nettype none

module crt_step
    import crt_pkg::*;
(
    input  wire t_state  i_state,
    input  wire t_cfg    i_cfg,
    input  wire t_item   i_item,
    output t_state       o_state,
    output t_result      o_result
);

    logic       step_due;
    logic [3:0] tick_base;
    logic [7:0] step_inc;
    logic [5:0] sih_inc;
    logic [7:0] hour_inc;
    logic [7:0] on_len;
    logic [7:0] off_len;
    logic [8:0] period;
    logic       hit_fan, hit_burner, hit_restart, hit_off;
    t_state     tick_next;
    t_state     btn_next;

    // Tick path: optional minute step, then schedule update
    always_comb begin
        step_due  = (i_state.tick_count >= i_cfg.ticks_per_step);
        tick_base = step_due ? 4'd0 : i_state.tick_count;
        step_inc  = i_state.step_count;
        sih_inc   = i_state.steps_in_hour;
        hour_inc  = i_state.hour_count;
        if (step_due) begin
            step_inc = i_state.step_count + 8'd1;
            sih_inc  = i_state.steps_in_hour + 6'd1;
            if (sih_inc == STEPS_PER_HOUR) begin
                sih_inc  = 6'd0;
                hour_inc = i_state.hour_count + 8'd1;
            end
        end

        if (i_state.fan_selected) begin
            on_len  = i_cfg.fan_on_steps;
            off_len = i_cfg.fan_off_steps;
        end else begin
            on_len = i_cfg.burner_on_steps;
            priority if (hour_inc < HOUR_MID_START) begin
                off_len = i_cfg.burner_off_early;
            end else if (hour_inc < HOUR_LATE_START) begin
                off_len = i_cfg.burner_off_mid;
            end else begin
                off_len = i_cfg.burner_off_late;
            end
        end
        period = {1'b0, on_len} + {1'b0, off_len};

        tick_next               = i_state;
        tick_next.steps_in_hour = sih_inc;
        tick_next.step_count    = step_inc;
        tick_next.hour_count    = hour_inc;
        tick_next.tick_count    = tick_base + 4'd1;
        if (hour_inc < i_cfg.shutoff_hours) begin
            if (step_inc < on_len) begin
                tick_next.relay_level = 1'b1;
            end else begin
                tick_next.relay_level = 1'b0;
                if ({1'b0, step_inc} >= period) begin
                    tick_next.step_count = 8'd0;
                end
            end
        end else begin
            tick_next.relay_level = 1'b0;
            if (hour_inc == HOUR_SATURATE) begin
                tick_next.hour_count = i_cfg.shutoff_hours;
            end
        end
    end

    // Button path: every matching mask acts, later ones win
    always_comb begin
        hit_fan     = |(i_item.button_code & BTN_FAN_MASK);
        hit_burner  = |(i_item.button_code & BTN_BURNER_MASK);
        hit_restart = |(i_item.button_code & BTN_RESTART_MASK);
        hit_off     = |(i_item.button_code & BTN_OFF_MASK);

        btn_next             = i_state;
        btn_next.relay_level = i_state.relay_level ^ hit_fan ^ hit_burner;
        if (hit_burner) begin
            btn_next.fan_selected = 1'b0;
        end else if (hit_fan) begin
            btn_next.fan_selected = 1'b1;
        end
        if (hit_off) begin
            btn_next.hour_count  = i_cfg.shutoff_hours + 8'd1;
            btn_next.step_count  = 8'd0;
            btn_next.relay_level = 1'b0;
        end else if (hit_restart) begin
            btn_next.hour_count  = 8'd0;
            btn_next.step_count  = 8'd0;
            btn_next.relay_level = 1'b1;
        end
    end

    always_comb begin
        o_state           = (i_item.mode == MODE_BUTTON) ? btn_next : tick_next;
        o_result.relay_on = o_state.relay_level;
        o_result.fan_mode = o_state.fan_selected;
        o_result.running  = (o_state.hour_count < i_cfg.shutoff_hours);
    end

endmodule

`default_nettype wire
